// ===== src/polygon_area_perimeter_unit_defines.svh =====
// assertion macros for the polygon area and perimeter unit
`ifndef POLYGON_AREA_PERIMETER_UNIT_DEFINES_SVH
`define POLYGON_AREA_PERIMETER_UNIT_DEFINES_SVH

// general property, clocked and held off during reset
`define PAPU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a stalled word keeps valid and payload
`define PAPU_ASSERT_HOLD(label, vld, rdy, data, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

// ===== src/papu_pkg.sv =====
package papu_pkg;

	localparam int COORD_W          = 12;
	localparam int FRAC_BITS        = 8;
	localparam int MAX_VERTICES_DEF = 256;

	localparam int DELTA_W    = COORD_W + 1;
	localparam int PROD_W     = 2 * DELTA_W;
	localparam int SQ_W       = 2 * COORD_W + 1;
	localparam int RAD_W      = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W     = (RAD_W + 1) / 2;
	localparam int AREA_ACC_W = 27;
	localparam int AREA_OUT_W = 25;
	localparam int PERIM_W    = 29;
	localparam int VCOUNT_W   = 9;

	localparam int IN_TDATA_W  = 2 * COORD_W;
	localparam int OUT_FIELD_W = AREA_OUT_W + PERIM_W + VCOUNT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_AREA,
		ST_SQRT,
		ST_PERIM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic init_first;
		logic set_ovf;
		logic mul;
		logic close_sel;
		logic area_acc;
		logic sqrt_start;
		logic perim_add;
		logic advance;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic sqrt_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== src/papu_sqrt.sv =====
module papu_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [papu_pkg::RAD_W-1:0]        radicand,
	output logic                              done,
	output logic [papu_pkg::ROOT_W-1:0]       root
);

	localparam int ROOT_W = papu_pkg::ROOT_W;
	localparam int PAD_W  = 2 * ROOT_W;
	localparam int ITER_W = $clog2(ROOT_W);

	logic [PAD_W-1:0]   rad_q;
	logic [ROOT_W+1:0]  rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [ITER_W-1:0]  iter_q;
	logic               busy_q;
	logic               done_q;

	logic [ROOT_W+1:0]  rem_sh;
	logic [ROOT_W+1:0]  trial;
	logic [ROOT_W+1:0]  diff;
	logic               ge;

	// one root bit per cycle, restoring form
	always_comb begin
		rem_sh = {rem_q[ROOT_W-1:0], rad_q[PAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		ge     = (rem_sh >= trial);
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= PAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? diff : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== src/papu_datapath.sv =====
module papu_datapath #(
	parameter int MAX_VERTICES = papu_pkg::MAX_VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  papu_pkg::ctrl_cmd_t                 cmd,
	output papu_pkg::dp_status_t                status,
	input  logic [papu_pkg::COORD_W-1:0]        in_x,
	input  logic [papu_pkg::COORD_W-1:0]        in_y,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [papu_pkg::AREA_OUT_W-1:0]     out_area,
	output logic [papu_pkg::PERIM_W-1:0]        out_perim,
	output logic [papu_pkg::VCOUNT_W-1:0]       out_count,
	output logic                                out_ovf
);

	localparam int COORD_W    = papu_pkg::COORD_W;
	localparam int DELTA_W    = papu_pkg::DELTA_W;
	localparam int PROD_W     = papu_pkg::PROD_W;
	localparam int SQ_W       = papu_pkg::SQ_W;
	localparam int RAD_W      = papu_pkg::RAD_W;
	localparam int ROOT_W     = papu_pkg::ROOT_W;
	localparam int AREA_ACC_W = papu_pkg::AREA_ACC_W;
	localparam int AREA_OUT_W = papu_pkg::AREA_OUT_W;
	localparam int PERIM_W    = papu_pkg::PERIM_W;
	localparam int VCOUNT_W   = papu_pkg::VCOUNT_W;
	localparam int CNT_W      = $clog2(MAX_VERTICES + 1);

	logic [COORD_W-1:0]          first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [COORD_W-1:0]          cur_x_q, cur_y_q;
	logic signed [AREA_ACC_W-1:0] area_q;
	logic [PERIM_W-1:0]          perim_q;
	logic [CNT_W-1:0]            count_q;
	logic                        ovf_q;

	logic signed [PROD_W-1:0]    prod_a_s1, prod_b_s1;
	logic [SQ_W-2:0]             sqx_s1, sqy_s1;

	logic                        out_valid_q;
	logic [AREA_OUT_W-1:0]       out_area_q;
	logic [PERIM_W-1:0]          out_perim_q;
	logic [VCOUNT_W-1:0]         out_count_q;
	logic                        out_ovf_q;

	logic signed [DELTA_W-1:0]   ax, ay, bx, by, ex, ey;
	logic [COORD_W-1:0]          tgt_x, tgt_y;
	logic signed [PROD_W-1:0]    ex_sq, ey_sq;
	logic signed [AREA_ACC_W:0]  area_sum_w;
	logic [AREA_ACC_W-1:0]       area_next;
	logic [AREA_ACC_W-1:0]       area_mag;
	logic [AREA_OUT_W-1:0]       area_out;
	logic [SQ_W-1:0]             sq_sum;
	logic [RAD_W-1:0]            radicand;
	logic [ROOT_W-1:0]           root;
	logic                        sqrt_done;
	logic [PERIM_W:0]            perim_sum_w;
	logic [PERIM_W-1:0]          perim_next;

	papu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (root)
	);

	always_comb begin
		tgt_x = cmd.close_sel ? first_x_q : cur_x_q;
		tgt_y = cmd.close_sel ? first_y_q : cur_y_q;
		ax    = $signed({1'b0, prev_x_q}) - $signed({1'b0, first_x_q});
		ay    = $signed({1'b0, prev_y_q}) - $signed({1'b0, first_y_q});
		bx    = $signed({1'b0, cur_x_q}) - $signed({1'b0, first_x_q});
		by    = $signed({1'b0, cur_y_q}) - $signed({1'b0, first_y_q});
		ex    = $signed({1'b0, prev_x_q}) - $signed({1'b0, tgt_x});
		ey    = $signed({1'b0, prev_y_q}) - $signed({1'b0, tgt_y});
		ex_sq = ex * ex;
		ey_sq = ey * ey;

		// fan term added with saturation at the accumulator limits
		area_sum_w = (AREA_ACC_W + 1)'(area_q) + (AREA_ACC_W + 1)'(prod_a_s1)
			- (AREA_ACC_W + 1)'(prod_b_s1);
		if (area_sum_w[AREA_ACC_W] != area_sum_w[AREA_ACC_W-1]) begin
			area_next = {area_sum_w[AREA_ACC_W], {(AREA_ACC_W - 1){~area_sum_w[AREA_ACC_W]}}};
		end else begin
			area_next = area_sum_w[AREA_ACC_W-1:0];
		end

		area_mag = area_q[AREA_ACC_W-1] ? AREA_ACC_W'(-area_q) : AREA_ACC_W'(area_q);
		area_out = (|area_mag[AREA_ACC_W-1:AREA_OUT_W]) ? '1 : area_mag[AREA_OUT_W-1:0];

		sq_sum   = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		radicand = RAD_W'(sq_sum) << (2 * papu_pkg::FRAC_BITS);

		perim_sum_w = {1'b0, perim_q} + (PERIM_W + 1)'(root);
		perim_next  = perim_sum_w[PERIM_W] ? '1 : perim_sum_w[PERIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			area_q      <= '0;
			perim_q     <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_first) begin
				first_x_q <= in_x;
				first_y_q <= in_y;
				prev_x_q  <= in_x;
				prev_y_q  <= in_y;
				count_q   <= CNT_W'(1);
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.area_acc) begin
				area_q <= area_next;
			end
			if (cmd.perim_add) begin
				perim_q <= perim_next;
			end
			if (cmd.advance) begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
				count_q  <= count_q + 1'b1;
			end
			if (cmd.emit) begin
				first_x_q   <= '0;
				first_y_q   <= '0;
				prev_x_q    <= '0;
				prev_y_q    <= '0;
				area_q      <= '0;
				perim_q     <= '0;
				count_q     <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_x_q <= in_x;
			cur_y_q <= in_y;
		end
		if (cmd.mul) begin
			prod_a_s1 <= ax * by;
			prod_b_s1 <= ay * bx;
			sqx_s1    <= (SQ_W - 1)'(ex_sq);
			sqy_s1    <= (SQ_W - 1)'(ey_sq);
		end
		if (cmd.emit) begin
			out_area_q  <= area_out;
			out_perim_q <= perim_q;
			out_count_q <= VCOUNT_W'(count_q);
			out_ovf_q   <= ovf_q;
		end
	end

	assign status.count_zero = (count_q == '0);
	assign status.count_full = (count_q == CNT_W'(MAX_VERTICES));
	assign status.sqrt_done  = sqrt_done;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_area  = out_area_q;
	assign out_perim = out_perim_q;
	assign out_count = out_count_q;
	assign out_ovf   = out_ovf_q;

endmodule

// ===== src/papu_ctrl.sv =====
module papu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_last,
	output logic                  in_ready,
	input  papu_pkg::dp_status_t  status,
	output papu_pkg::ctrl_cmd_t   cmd
);

	papu_pkg::state_t state_q, state_d;
	logic             closing_q, closing_d;
	logic             last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= papu_pkg::ST_IDLE;
			closing_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			closing_q <= closing_d;
			last_q    <= last_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		closing_d = closing_q;
		last_d    = last_q;
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			papu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					last_d      = in_last;
					if (status.count_zero) begin
						cmd.init_first = 1'b1;
						if (in_last) begin
							closing_d = 1'b1;
							state_d   = papu_pkg::ST_MUL;
						end
					end else if (status.count_full) begin
						// vertex dropped, only the closing edge may follow
						cmd.set_ovf = 1'b1;
						if (in_last) begin
							closing_d = 1'b1;
							state_d   = papu_pkg::ST_MUL;
						end
					end else begin
						closing_d = 1'b0;
						state_d   = papu_pkg::ST_MUL;
					end
				end
			end
			papu_pkg::ST_MUL: begin
				cmd.mul       = 1'b1;
				cmd.close_sel = closing_q;
				state_d       = papu_pkg::ST_AREA;
			end
			papu_pkg::ST_AREA: begin
				cmd.area_acc   = !closing_q;
				cmd.sqrt_start = 1'b1;
				state_d        = papu_pkg::ST_SQRT;
			end
			papu_pkg::ST_SQRT: begin
				if (status.sqrt_done) begin
					state_d = papu_pkg::ST_PERIM;
				end
			end
			papu_pkg::ST_PERIM: begin
				cmd.perim_add = 1'b1;
				cmd.advance   = !closing_q;
				if (closing_q) begin
					state_d = papu_pkg::ST_EMIT;
				end else if (last_q) begin
					closing_d = 1'b1;
					state_d   = papu_pkg::ST_MUL;
				end else begin
					state_d = papu_pkg::ST_IDLE;
				end
			end
			papu_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					closing_d = 1'b0;
					state_d   = papu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = papu_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/polygon_area_perimeter_unit.sv =====
// a vertex that adds an edge goes through accept, multiply, area add, the
// one-bit-per-cycle square root unit (21 root bits and done), and the perimeter add
// a last vertex adds the closing edge too, then its result is emitted; this holds also
// when it is the first or a dropped vertex; a full output register holds the emit step
// other first and dropped vertices are taken without starting work; a new vertex is taken while the
// result word waits. reset clears all sums, counts and the result valid
module polygon_area_perimeter_unit #(
	parameter int MAX_VERTICES = papu_pkg::MAX_VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [papu_pkg::IN_TDATA_W-1:0]     s_tdata,  // x_coord, y_coord
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [papu_pkg::OUT_TDATA_W-1:0]    m_tdata,  // area_doubled, perimeter_q8, vertex_count
	output logic [0:0]                          m_tuser   // overflow
);

	papu_pkg::ctrl_cmd_t               cmd;
	papu_pkg::dp_status_t              status;
	logic [papu_pkg::AREA_OUT_W-1:0]   area;
	logic [papu_pkg::PERIM_W-1:0]      perim;
	logic [papu_pkg::VCOUNT_W-1:0]     count;
	logic                              ovf;

	papu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	papu_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_x      (s_tdata[papu_pkg::COORD_W-1:0]),
		.in_y      (s_tdata[2*papu_pkg::COORD_W-1:papu_pkg::COORD_W]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_area  (area),
		.out_perim (perim),
		.out_count (count),
		.out_ovf   (ovf)
	);

	assign m_tdata    = papu_pkg::OUT_TDATA_W'({count, perim, area});
	assign m_tuser[0] = ovf;

endmodule

// ===== src/papu_checker.sv =====
`include "polygon_area_perimeter_unit_defines.svh"

module papu_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [papu_pkg::IN_TDATA_W-1:0]     s_tdata,
	input logic                                s_tlast,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [papu_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input logic [0:0]                          m_tuser
);

	// a closing vertex always starts work, so input is held off next cycle
	`PAPU_ASSERT(a_last_busy, (s_tvalid && s_tready && s_tlast) |=> !s_tready, "input still open after last vertex")

	// a new result word comes out of the emit step, during which input is held
	`PAPU_ASSERT(a_emit_blocks, $rose(m_tvalid) |-> !$past(s_tready), "result word appeared while input was open")

	`PAPU_ASSERT_HOLD(a_in_hold, s_tvalid, s_tready, {s_tdata, s_tlast}, "stalled input word changed")

	`PAPU_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, {m_tdata, m_tuser}, "stalled result word changed")

endmodule

bind polygon_area_perimeter_unit papu_checker u_papu_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int COORD_W          = papu_pkg::COORD_W;
	localparam int FRAC_BITS        = papu_pkg::FRAC_BITS;
	localparam int MAX_VERTICES_DEF = papu_pkg::MAX_VERTICES_DEF;
	localparam int AREA_ACC_W       = papu_pkg::AREA_ACC_W;
	localparam int AREA_OUT_W       = papu_pkg::AREA_OUT_W;
	localparam int PERIM_W          = papu_pkg::PERIM_W;
	localparam int VCOUNT_W         = papu_pkg::VCOUNT_W;
	localparam int IN_TDATA_W       = papu_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W      = papu_pkg::OUT_TDATA_W;

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int RANDOM_ITEMS  = 80;
	localparam int HOLD_CYCLES   = 3000;
	localparam int DRAIN_CYCLES  = 100;
	localparam int COORD_TOP     = (1 << COORD_W) - 1;

	typedef struct {
		bit [AREA_OUT_W-1:0] area_doubled;
		bit [PERIM_W-1:0]    perimeter_q8;
		bit [VCOUNT_W-1:0]   vertex_count;
		bit                  overflow;
	} polygon_result_t;

	class polygon_scoreboard;
		longint first_x, first_y, prev_x, prev_y;
		longint area_sum;
		longint perimeter_sum;
		int     vertices;
		bit     overflow_seen;
		polygon_result_t expected_polygons[$];
		int results_checked;
		int mismatches;
		int overflowed;
		int area_clipped;

		function void clear_polygon();
			first_x = 0;
			first_y = 0;
			prev_x = 0;
			prev_y = 0;
			area_sum = 0;
			perimeter_sum = 0;
			vertices = 0;
			overflow_seen = 1'b0;
		endfunction

		function new();
			clear_polygon();
			results_checked = 0;
			mismatches = 0;
			overflowed = 0;
			area_clipped = 0;
		endfunction

		function longint unsigned floor_root(longint unsigned radicand);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int b = 31; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= radicand)
					root = trial;
			end
			return root;
		endfunction

		function void add_edge(longint ax, longint ay, longint bx, longint by);
			longint unsigned sq;
			longint unsigned len;
			sq = (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
			len = floor_root(sq << (2 * FRAC_BITS));
			perimeter_sum = perimeter_sum + len;
			if (perimeter_sum > (64'd1 << PERIM_W) - 1)
				perimeter_sum = (64'd1 << PERIM_W) - 1;
		endfunction

		function void note_vertex(bit [COORD_W-1:0] x, bit [COORD_W-1:0] y, bit closing);
			longint cx;
			longint cy;
			longint term;
			longint mag;
			polygon_result_t res;
			cx = longint'(x);
			cy = longint'(y);
			if (vertices == 0) begin
				first_x = cx;
				first_y = cy;
				prev_x = cx;
				prev_y = cy;
				vertices = 1;
			end else if (vertices < MAX_VERTICES_DEF) begin
				term = (prev_x - first_x) * (cy - first_y) - (prev_y - first_y) * (cx - first_x);
				area_sum = area_sum + term;
				if (area_sum > (64'sd1 <<< (AREA_ACC_W - 1)) - 1)
					area_sum = (64'sd1 <<< (AREA_ACC_W - 1)) - 1;
				if (area_sum < -(64'sd1 <<< (AREA_ACC_W - 1)))
					area_sum = -(64'sd1 <<< (AREA_ACC_W - 1));
				add_edge(prev_x, prev_y, cx, cy);
				prev_x = cx;
				prev_y = cy;
				vertices++;
			end else begin
				overflow_seen = 1'b1;
			end
			if (closing) begin
				add_edge(prev_x, prev_y, first_x, first_y);
				mag = (area_sum < 0) ? -area_sum : area_sum;
				if (mag > (64'sd1 <<< AREA_OUT_W) - 1) begin
					mag = (64'sd1 <<< AREA_OUT_W) - 1;
					area_clipped++;
				end
				res.area_doubled = mag[AREA_OUT_W-1:0];
				res.perimeter_q8 = perimeter_sum[PERIM_W-1:0];
				res.vertex_count = vertices[VCOUNT_W-1:0];
				res.overflow = overflow_seen;
				if (overflow_seen)
					overflowed++;
				expected_polygons.push_back(res);
				clear_polygon();
			end
		endfunction

		function void report(string what, longint unsigned want, longint unsigned got);
			if (mismatches < 10)
				$display("mismatch on result %0d, %s: expected %0d, got %0d",
					results_checked, what, want, got);
			mismatches++;
		endfunction

		function void check_result(bit [OUT_TDATA_W-1:0] word, bit ovf);
			polygon_result_t want;
			bit [AREA_OUT_W-1:0] got_area;
			bit [PERIM_W-1:0]    got_perim;
			bit [VCOUNT_W-1:0]   got_count;
			got_area = word[AREA_OUT_W-1:0];
			got_perim = word[AREA_OUT_W +: PERIM_W];
			got_count = word[AREA_OUT_W + PERIM_W +: VCOUNT_W];
			if (expected_polygons.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: area %0d, perimeter %0d, count %0d, overflow %0d",
						got_area, got_perim, got_count, ovf);
				mismatches++;
			end else begin
				want = expected_polygons.pop_front();
				if (got_area != want.area_doubled)
					report("area_doubled", 64'(want.area_doubled), 64'(got_area));
				if (got_perim != want.perimeter_q8)
					report("perimeter_q8", 64'(want.perimeter_q8), 64'(got_perim));
				if (got_count != want.vertex_count)
					report("vertex_count", 64'(want.vertex_count), 64'(got_count));
				if (ovf != want.overflow)
					report("overflow", 64'(want.overflow), 64'(ovf));
			end
			results_checked++;
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]             m_tuser;

	polygon_scoreboard sb = new();
	int  cycle_count = 0;
	int  vertices_sent = 0;
	bit  sender_burst = 1'b0;

	polygon_area_perimeter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_vertex(s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W], s_tlast);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser[0]);
		end
	end

	function automatic int idle_length();
		int r;
		if (sender_burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_coord();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return 0;
		if (r < 4)
			return COORD_TOP;
		return $urandom_range(0, COORD_TOP);
	endfunction

	task automatic send_vertex(int x, int y, bit closing);
		int gap;
		gap = idle_length();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {COORD_W'(y), COORD_W'(x)};
		s_tlast <= closing;
		do @(posedge clk); while (!s_tready);
		vertices_sent++;
	endtask

	task automatic send_random_polygon();
		int n;
		int r;
		int span;
		int base_x;
		int base_y;
		r = $urandom_range(0, 99);
		if (r < 12)
			n = $urandom_range(1, 2);
		else if (r < 80)
			n = $urandom_range(3, 6);
		else
			n = $urandom_range(7, 16);
		span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 300) : COORD_TOP;
		base_x = $urandom_range(0, COORD_TOP - span);
		base_y = $urandom_range(0, COORD_TOP - span);
		for (int k = 1; k <= n; k++) begin
			if (span == COORD_TOP)
				send_vertex(pick_coord(), pick_coord(), k == n);
			else
				send_vertex(base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
					k == n);
		end
	endtask

	// fan around the center through the four corners, so every term has one sign
	task automatic send_spiral(bit clockwise, int n);
		int corner;
		int jx;
		int jy;
		int cx;
		int cy;
		send_vertex(2048 - $urandom_range(0, 8), 2048 - $urandom_range(0, 8), 1'b0);
		for (int k = 1; k < n; k++) begin
			corner = clockwise ? (4 - (k % 4)) % 4 : k % 4;
			jx = $urandom_range(0, 31);
			jy = $urandom_range(0, 31);
			cx = (corner == 0 || corner == 3) ? COORD_TOP - jx : jx;
			cy = (corner == 0 || corner == 1) ? COORD_TOP - jy : jy;
			send_vertex(cx, cy, k == n - 1);
		end
	endtask

	initial begin : stimulus
		int start_count;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_vertex(0, 0, 1'b1);
		send_vertex(0, 0, 1'b0);
		send_vertex(COORD_TOP, 0, 1'b0);
		send_vertex(COORD_TOP, COORD_TOP, 1'b1);
		send_vertex(COORD_TOP, COORD_TOP, 1'b0);
		send_vertex(0, COORD_TOP, 1'b0);
		send_vertex(0, 0, 1'b1);
		send_vertex(0, COORD_TOP, 1'b0);
		send_vertex(COORD_TOP, 0, 1'b1);
		send_vertex(5, 5, 1'b0);
		send_vertex(10, 10, 1'b0);
		send_vertex(20, 20, 1'b1);
		send_vertex(100, 100, 1'b0);
		send_vertex(100, 100, 1'b0);
		send_vertex(100, 100, 1'b1);
		send_vertex(1, 1, 1'b0);
		send_vertex(COORD_TOP - 1, 1, 1'b0);
		send_vertex(COORD_TOP - 1, COORD_TOP - 1, 1'b0);
		send_vertex(1, COORD_TOP - 1, 1'b1);

		start_count = vertices_sent;
		while (vertices_sent - start_count < RANDOM_ITEMS) begin
			sender_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				send_spiral($urandom_range(0, 1) == 1, $urandom_range(5, 20));
			else
				send_random_polygon();
		end

		// a full polygon of diagonal edges, then one whose closing vertex is dropped
		sender_burst = 1'b0;
		for (int k = 1; k <= MAX_VERTICES_DEF; k++) begin
			if (k % 2)
				send_vertex(0, 0, k == MAX_VERTICES_DEF);
			else
				send_vertex(COORD_TOP, COORD_TOP, k == MAX_VERTICES_DEF);
		end
		for (int k = 1; k <= MAX_VERTICES_DEF + 2; k++)
			send_vertex(pick_coord(), pick_coord(), k == MAX_VERTICES_DEF + 2);

		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		while (sb.expected_polygons.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("testbench: %0d vertices in %0d polygons checked, %0d over the vertex limit,",
			vertices_sent, sb.results_checked, sb.overflowed);
		$display("testbench: %0d areas clipped, %0d mismatches in %0d cycles",
			sb.area_clipped, sb.mismatches, cycle_count);
		if (sb.mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin : result_sink
		int mode;
		int span;
		bit held_off;
		span = 0;
		mode = 0;
		held_off = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && sb.results_checked >= 10) begin
				// long hold-off while vertices keep coming, so the input backs up
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 9);
					span = $urandom_range(20, 200);
				end
				span--;
				if (mode < 4)
					m_tready <= 1'b1;
				else if (mode < 8)
					m_tready <= ($urandom_range(0, 3) != 0);
				else
					m_tready <= ($urandom_range(0, 15) == 0);
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= LIMIT_CYCLES);
		$display("testbench: timeout after %0d cycles", cycle_count);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
